[design/midi_split_and_control_remapper_assert.svh]
// Assertion macros used by the remapper controller module.
`ifndef MIDI_SPLIT_AND_CONTROL_REMAPPER_ASSERT_SVH
`define MIDI_SPLIT_AND_CONTROL_REMAPPER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define MSCR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("remapper assertion failed");

// Condition implies consequence in the next cycle.
`define MSCR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("remapper assertion failed");

`endif

[design/mscr_pkg.sv]
// Types and constants shared by the MIDI split and control remapper modules.
package mscr_pkg;

  // Status byte codes.
  localparam logic [7:0] ST_NOTE_OFF = 8'd128;
  localparam logic [7:0] ST_NOTE_ON  = 8'd144;
  localparam logic [7:0] ST_CC       = 8'd176;
  localparam logic [7:0] ST_PC       = 8'd192;
  localparam logic [7:0] ST_LIMIT    = 8'd254;

  // Controller numbers.
  localparam logic [6:0] CC_SPLIT   = 7'd19;
  localparam logic [6:0] CC_PANIC   = 7'd14;
  localparam logic [6:0] CC_CLEAR   = 7'd10;
  localparam logic [6:0] CC_MOD     = 7'd1;
  localparam logic [6:0] CC_BREATH  = 7'd2;
  localparam logic [6:0] CC_PROG_DN = 7'd11;
  localparam logic [6:0] CC_PROG_UP = 7'd12;
  localparam logic [6:0] CC_ALL_OFF = 7'd123;
  localparam logic [6:0] CC_VOLUME  = 7'd7;
  localparam logic [6:0] CC_REVERB  = 7'd91;
  localparam logic [6:0] PROG_MAX   = 7'd127;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic [1:0] idx;
    logic [3:0] chan;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] len;
    logic       all_off;
  } dp_status_t;

endpackage

[design/midi_split_and_control_remapper.sv]
// An accepted word is decoded into the message registers as it is taken; the controller then
// passes through its check state before the first output word is shown. Output words then go
// out one per cycle while out_ready is high, up to 3, or 3 per channel for the all-notes-off
// burst (48 at 16 channels). A new input word is taken only once all output words of the last are out.
// Synchronous active-high rst clears all message state but the word buffer; split_point returns to 54.
module midi_split_and_control_remapper
  import mscr_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  midi_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_SPLIT_POINT = 1'b0;
  localparam logic [6:0] SPLIT_POINT_RESET = 7'd54;

  logic [6:0] split_point;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration register write and read.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_point <= SPLIT_POINT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SPLIT_POINT) begin
      split_point <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == REG_SPLIT_POINT) ? {25'b0, split_point} : 32'd0;

  mscr_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .last_of_run(last_of_run),
    .status(status),
    .cmd(cmd)
  );

  mscr_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .midi_byte(midi_byte),
    .split_point(split_point),
    .cmd(cmd),
    .status(status),
    .out_byte(out_byte)
  );

endmodule

[design/mscr_datapath.sv]
// Datapath: message state, decode of one received byte and output byte select.
module mscr_datapath
  import mscr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] midi_byte,
  input  logic [6:0] split_point,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic [7:0] out_byte
);

  logic [7:0] running_status, running_status_next;
  logic       second_pending, second_pending_next;
  logic [6:0] first_data, first_data_next;
  logic       split_on, split_on_next;
  logic [6:0] program_number, program_number_next;
  logic [7:0] msg0, msg0_next;
  logic [7:0] msg1, msg1_next;
  logic [7:0] msg2, msg2_next;
  logic [1:0] len, len_next;
  logic       all_off, all_off_next;
  logic [7:0] note_st;
  logic [7:0] pc_st;

  // Note status after the split rule, and the program change status of the channel.
  always_comb begin
    note_st = running_status;
    if ((running_status == ST_NOTE_ON || running_status == ST_NOTE_OFF) && split_on &&
        first_data <= split_point) begin
      note_st = running_status + 8'd1;
    end
    pc_st = ST_PC | {4'b0, running_status[3:0]};
  end

  // Decode of one accepted byte into state updates and an output word buffer.
  always_comb begin
    running_status_next = running_status;
    second_pending_next = second_pending;
    first_data_next     = first_data;
    split_on_next       = split_on;
    program_number_next = program_number;
    msg0_next           = msg0;
    msg1_next           = msg1;
    msg2_next           = msg2;
    len_next            = len;
    all_off_next        = all_off;
    if (cmd.load) begin
      len_next     = 2'd0;
      all_off_next = 1'b0;
      if (midi_byte >= ST_LIMIT) begin
        len_next = 2'd0;
      end else if (midi_byte[7]) begin
        running_status_next = midi_byte;
      end else if (!second_pending) begin
        second_pending_next = 1'b1;
        first_data_next     = midi_byte[6:0];
        if (running_status[7:4] == 4'hE) begin
          msg0_next = running_status;
          msg1_next = midi_byte;
          len_next  = 2'd2;
        end
      end else begin
        second_pending_next = 1'b0;
        if (running_status[7:5] == 3'b100) begin
          // Note on or note off, with the split rule applied.
          if (running_status > ST_NOTE_ON) begin
            split_on_next = 1'b0;
          end
          msg0_next = note_st;
          msg1_next = {1'b0, first_data};
          msg2_next = midi_byte;
          len_next  = 2'd3;
        end else if (running_status[7:4] == 4'hB && midi_byte != 8'd0) begin
          // Control change with a nonzero value.
          case (first_data)
            CC_SPLIT: begin
              first_data_next = 7'd0;
              split_on_next   = ~split_on;
            end
            CC_PANIC: begin
              first_data_next = 7'd127;
              all_off_next    = 1'b1;
              len_next        = 2'd3;
            end
            CC_CLEAR: begin
              len_next = 2'd0;
            end
            CC_MOD: begin
              first_data_next = CC_VOLUME;
              msg0_next       = running_status;
              msg1_next       = {1'b0, CC_VOLUME};
              msg2_next       = midi_byte;
              len_next        = 2'd3;
            end
            CC_BREATH: begin
              first_data_next = CC_REVERB;
              msg0_next       = running_status;
              msg1_next       = {1'b0, CC_REVERB};
              msg2_next       = midi_byte;
              len_next        = 2'd3;
            end
            CC_PROG_DN: begin
              running_status_next = pc_st;
              if (program_number != 7'd0) begin
                program_number_next = program_number - 7'd1;
              end
              msg0_next = pc_st;
              msg1_next = {1'b0, program_number_next};
              len_next  = 2'd2;
            end
            CC_PROG_UP: begin
              running_status_next = pc_st;
              if (program_number != PROG_MAX) begin
                program_number_next = program_number + 7'd1;
              end
              msg0_next = pc_st;
              msg1_next = {1'b0, program_number_next};
              len_next  = 2'd2;
            end
            default: begin
              len_next = 2'd0;
            end
          endcase
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= 8'd0;
      second_pending <= 1'b0;
      first_data     <= 7'd0;
      split_on       <= 1'b0;
      program_number <= 7'd0;
      len            <= 2'd0;
      all_off        <= 1'b0;
    end else begin
      running_status <= running_status_next;
      second_pending <= second_pending_next;
      first_data     <= first_data_next;
      split_on       <= split_on_next;
      program_number <= program_number_next;
      len            <= len_next;
      all_off        <= all_off_next;
    end
  end

  // Word buffer.
  always_ff @(posedge clk) begin
    msg0 <= msg0_next;
    msg1 <= msg1_next;
    msg2 <= msg2_next;
  end

  assign status.len     = len;
  assign status.all_off = all_off;

  // Output word select: buffered message, or the all-notes-off sweep.
  always_comb begin
    if (all_off) begin
      case (cmd.idx)
        2'd0:    out_byte = ST_CC | {4'b0, cmd.chan};
        2'd1:    out_byte = {1'b0, CC_ALL_OFF};
        default: out_byte = 8'd0;
      endcase
    end else begin
      case (cmd.idx)
        2'd0:    out_byte = msg0;
        2'd1:    out_byte = msg1;
        default: out_byte = msg2;
      endcase
    end
  end

endmodule

[design/mscr_ctrl.sv]
// Controller: accepts one word, then steps through the output words it causes.
module mscr_ctrl
  import mscr_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       last_of_run,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SEND  = 2'd2;
  localparam logic [3:0] CHAN_LAST = 4'(NUM_CHANNELS - 1);

  logic [1:0] state, state_next;
  logic [1:0] idx, idx_next;
  logic [3:0] chan, chan_next;
  logic       word_last;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);
  assign word_last = (idx == status.len - 2'd1);
  assign last_of_run = word_last && (!status.all_off || chan == CHAN_LAST);

  assign cmd.load = in_valid && in_ready;
  assign cmd.idx  = idx;
  assign cmd.chan = chan;

  // Next state and word position.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    chan_next  = chan;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_next   = 2'd0;
        chan_next  = 4'd0;
        state_next = (status.len == 2'd0) ? S_IDLE : S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          if (last_of_run) begin
            state_next = S_IDLE;
          end else if (word_last) begin
            idx_next  = 2'd0;
            chan_next = chan + 4'd1;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    chan <= chan_next;
  end

`include "midi_split_and_control_remapper_assert.svh"

  `MSCR_ASSERT_IMP(a_no_accept_while_sending, clk, rst, out_valid, !in_ready)
  `MSCR_ASSERT_NXT(a_accept_goes_to_check, clk, rst, in_valid && in_ready, state == S_CHECK)
  `MSCR_ASSERT_IMP(a_index_in_message, clk, rst, state == S_SEND, idx < status.len)
  `MSCR_ASSERT_IMP(a_channel_in_range, clk, rst, state == S_SEND, chan <= CHAN_LAST)

endmodule
